// ----- hdl/pipt_pkg.sv -----
// ----------------------------------------------------------------------------
// pipt_pkg: shared types for the point-in-polygon test unit
// Item kinds, result status codes, controller states and the step/result
// structs passed between the controller and the edge pipeline.
// ----------------------------------------------------------------------------
package pipt_pkg;

  // Width of the ray length register (fixed by the register map).
  localparam int unsigned RAY_BITS = 23;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_QUERY  = 2'd2
  } pipt_kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RAY_ZERO = 2'd1,
    ST_EMPTY    = 2'd2
  } pipt_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_RESULT
  } pipt_state_e;

  // One step of the vertex walk, aligned with the memory read data.
  typedef struct packed {
    logic vld;    // step carries a vertex (or the wrap vertex)
    logic first;  // vertex 0: no edge yet, parity restarts
    logic wrap;   // closing edge back to vertex 0, last step of a query
  } pipt_step_t;

  // Status back from the edge pipeline.
  typedef struct packed {
    logic done;   // pulse: closing edge has been counted
    logic odd;    // crossing parity
  } pipt_res_t;

endpackage

// ----- hdl/pipt_vertex_ram.sv -----
// ----------------------------------------------------------------------------
// pipt_vertex_ram: vertex store
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module pipt_vertex_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/pipt_edge_pipe.sv -----
// ----------------------------------------------------------------------------
// pipt_edge_pipe: per-edge crossing test
// Takes one vertex a cycle, forms the edge from the previous vertex, and
// tests it against the horizontal ray: diffs, products, sign test, parity.
// ----------------------------------------------------------------------------
module pipt_edge_pipe
  import pipt_pkg::*;
#(
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pipt_step_t                   step_i,
  input  logic signed [COORD_BITS-1:0] vx_i,
  input  logic signed [COORD_BITS-1:0] vy_i,
  input  logic signed [COORD_BITS-1:0] pt_x_i,
  input  logic signed [COORD_BITS-1:0] pt_y_i,
  input  logic [RAY_BITS-1:0]          ray_i,
  output pipt_res_t                    res_o
);

  localparam int unsigned DW  = COORD_BITS + 1;
  localparam int unsigned P1W = 2 * DW;
  localparam int unsigned P3W = RAY_BITS + 1 + DW;
  localparam int unsigned FW  = ((P1W > P3W) ? P1W : P3W) + 2;

  typedef struct packed {
    logic vld;
    logic edge_ok;
    logic first;
    logic wrap;
  } stage_tag_t;

  // vertex history
  logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q, v0_x_q, v0_y_q;
  logic signed [COORD_BITS-1:0] bx, by;

  // stage 1: differences
  logic signed [DW-1:0] dax_d, day_d, dbx_d, dby_d, dy_d;
  logic signed [DW-1:0] dax_q, day_q, dbx_q, dby_q, dy_q;
  logic                 ycross_q;
  stage_tag_t           tag1_d, tag1_q;

  // stage 2: products
  logic signed [P1W-1:0] p1_d, p2_d, p1_q, p2_q;
  logic signed [P3W-1:0] p3_d, p3_q;
  logic                  ycross2_q;
  stage_tag_t            tag2_q;

  // stage 3: sign test
  logic signed [FW-1:0] f1, f2;
  logic                 pos1, neg1, pos2, neg2, hit;
  logic                 parity_d, parity_q, done_d, done_q;

  // closing edge takes vertex 0 as its end point
  assign bx = step_i.wrap ? v0_x_q : vx_i;
  assign by = step_i.wrap ? v0_y_q : vy_i;

  always_ff @(posedge clk_i) begin
    if (step_i.vld) begin
      prev_x_q <= bx;
      prev_y_q <= by;
    end
    if (step_i.vld && step_i.first) begin
      v0_x_q <= vx_i;
      v0_y_q <= vy_i;
    end
  end

  always_comb begin
    dax_d = {prev_x_q[COORD_BITS-1], prev_x_q} - {pt_x_i[COORD_BITS-1], pt_x_i};
    day_d = {prev_y_q[COORD_BITS-1], prev_y_q} - {pt_y_i[COORD_BITS-1], pt_y_i};
    dbx_d = {bx[COORD_BITS-1], bx} - {pt_x_i[COORD_BITS-1], pt_x_i};
    dby_d = {by[COORD_BITS-1], by} - {pt_y_i[COORD_BITS-1], pt_y_i};
    dy_d  = {by[COORD_BITS-1], by} - {prev_y_q[COORD_BITS-1], prev_y_q};
    tag1_d.vld     = step_i.vld;
    tag1_d.edge_ok = step_i.vld && !step_i.first;
    tag1_d.first   = step_i.first;
    tag1_d.wrap    = step_i.wrap;
  end

  always_ff @(posedge clk_i) begin
    dax_q    <= dax_d;
    day_q    <= day_d;
    dbx_q    <= dbx_d;
    dby_q    <= dby_d;
    dy_q     <= dy_d;
    // ray level strictly above one end and at or below the other
    ycross_q <= day_d[DW-1] ^ dby_d[DW-1];
  end

  // cross(P) = dax*dby - dbx*day ; cross(P+L) = cross(P) - L*(by-ay)
  always_comb begin
    p1_d = P1W'(dax_q) * P1W'(dby_q);
    p2_d = P1W'(dbx_q) * P1W'(day_q);
    p3_d = P3W'($signed({1'b0, ray_i})) * P3W'(dy_q);
  end

  always_ff @(posedge clk_i) begin
    p1_q      <= p1_d;
    p2_q      <= p2_d;
    p3_q      <= p3_d;
    ycross2_q <= ycross_q;
  end

  always_comb begin
    f1       = FW'(p1_q) - FW'(p2_q);
    f2       = FW'(p1_q) - FW'(p2_q) - FW'(p3_q);
    neg1     = f1[FW-1];
    pos1     = !f1[FW-1] && (f1 != '0);
    neg2     = f2[FW-1];
    pos2     = !f2[FW-1] && (f2 != '0);
    hit      = tag2_q.edge_ok && ycross2_q && !((pos1 && pos2) || (neg1 && neg2));
    parity_d = tag2_q.first ? 1'b0 : (parity_q ^ hit);
    done_d   = tag2_q.vld && tag2_q.wrap;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q   <= '0;
      tag2_q   <= '0;
      parity_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      tag1_q <= tag1_d;
      tag2_q <= tag1_q;
      if (tag2_q.vld) begin
        parity_q <= parity_d;
      end
      done_q <= done_d;
    end
  end

  assign res_o.done = done_q;
  assign res_o.odd  = parity_q;

endmodule

// ----- hdl/point_in_polygon_test_unit.sv -----
// ----------------------------------------------------------------------------
// point_in_polygon_test_unit: ray-casting point-in-polygon test
// Vertex ring in on-chip memory; queries walk the ring edge by edge.
// ----------------------------------------------------------------------------
// Each input word clears the ring, appends a vertex, or queries a point.
// Clear and append give no result; an append to a full ring is dropped
// and sets the overflow flag until the next clear. A query casts a
// horizontal ray of cfg length from the point and returns the parity of
// the edges it crosses (edges touched at their lower end do not count,
// horizontal edges never count). A query over N stored vertices reads one
// vertex from memory per cycle, then tests the closing edge and waits for
// the edge test pipeline to drain. A query with zero ray length or an
// empty ring skips the walk and answers with an error status. The
// input stalls while a query is in flight; a finished result sits in the
// output register, so clears and appends flow on while it waits. Vertex
// memory needs no clearing pass: only entries below the fill count are read.
// The ray length register may only be written while the unit is idle.
// ----------------------------------------------------------------------------
module point_in_polygon_test_unit
  import pipt_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 256,
  parameter int unsigned COORD_BITS   = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input words
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   in_kind_i,
  input  logic signed [COORD_BITS-1:0] in_coord_x_i,
  input  logic signed [COORD_BITS-1:0] in_coord_y_i,
  // result words
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         out_inside_res_o,
  output logic [1:0]                   out_status_o,
  output logic                         out_overflowed_o,
  // ray length register
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [RAY_BITS-1:0]          cfg_ray_length_i
);

  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned VW = 2 * COORD_BITS;

  pipt_state_e state_q, state_d;

  logic [RAY_BITS-1:0] ray_q;
  logic [CW-1:0]       count_q, count_d;
  logic                ovf_q, ovf_d;
  logic [CW-1:0]       rd_idx_q, rd_idx_d;

  logic signed [COORD_BITS-1:0] pt_x_q, pt_y_q;

  logic         pend_odd_q, pend_odd_d, pend_ovf_q, pend_ovf_d;
  pipt_status_e pend_status_q, pend_status_d;

  logic         out_valid_q, out_valid_d;
  logic         out_inside_q, out_ovf_q;
  pipt_status_e out_status_q;

  logic         in_acc, out_free, load_out, scan_end;
  pipt_kind_e   kind;
  logic         we, re;
  pipt_step_t   step_d, step_q;
  pipt_res_t    res;
  logic [VW-1:0] rdata;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign kind     = pipt_kind_e'(in_kind_i);
  assign out_free = !out_valid_q || !out_stall_i;
  assign scan_end = (rd_idx_q == count_q);

  // ---------------------------------------------------------------- config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ray_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      ray_q <= cfg_ray_length_i;
    end
  end

  // ---------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && kind == KIND_QUERY) begin
          if (ray_q == '0 || count_q == '0) begin
            state_d = S_RESULT;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (res.done) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ------------------------------------------------------ state outputs
  always_comb begin
    in_stall_o   = 1'b1;
    re           = 1'b0;
    load_out     = 1'b0;
    step_d       = '0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
      end
      S_SCAN: begin
        // N reads, then one step with no read for the closing edge
        re           = !scan_end;
        step_d.vld   = 1'b1;
        step_d.first = (rd_idx_q == '0) && !scan_end;
        step_d.wrap  = scan_end;
      end
      S_DRAIN: begin
        in_stall_o = 1'b1;
      end
      S_RESULT: begin
        load_out = out_free;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  assign we = in_acc && (kind == KIND_APPEND) && (count_q < CW'(MAX_VERTICES));

  // ----------------------------------------------------- datapath next
  always_comb begin
    count_d       = count_q;
    ovf_d         = ovf_q;
    rd_idx_d      = rd_idx_q;
    pend_odd_d    = pend_odd_q;
    pend_ovf_d    = pend_ovf_q;
    pend_status_d = pend_status_q;
    out_valid_d   = out_valid_q;

    if (in_acc) begin
      case (kind)
        KIND_CLEAR: begin
          count_d = '0;
          ovf_d   = 1'b0;
        end
        KIND_APPEND: begin
          if (we) begin
            count_d = count_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
        KIND_QUERY: begin
          rd_idx_d   = '0;
          pend_odd_d = 1'b0;
          pend_ovf_d = ovf_q;
          if (ray_q == '0) begin
            pend_status_d = ST_RAY_ZERO;
          end else if (count_q == '0) begin
            pend_status_d = ST_EMPTY;
          end else begin
            pend_status_d = ST_OK;
          end
        end
        default: ;  // unused kind: no effect
      endcase
    end

    if (re) begin
      rd_idx_d = rd_idx_q + CW'(1);
    end

    if (state_q == S_DRAIN && res.done) begin
      pend_odd_d = res.odd;
    end

    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // ------------------------------------------------------------ registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      rd_idx_q    <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      rd_idx_q    <= rd_idx_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc && kind == KIND_QUERY) begin
      pt_x_q <= in_coord_x_i;
      pt_y_q <= in_coord_y_i;
    end
    pend_odd_q    <= pend_odd_d;
    pend_ovf_q    <= pend_ovf_d;
    pend_status_q <= pend_status_d;
    if (load_out) begin
      out_inside_q <= pend_odd_q;
      out_status_q <= pend_status_q;
      out_ovf_q    <= pend_ovf_q;
    end
  end

  // ---------------------------------------------------------- vertex store
  pipt_vertex_ram #(
    .DEPTH (MAX_VERTICES),
    .WIDTH (VW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i ({in_coord_x_i, in_coord_y_i}),
    .re_i    (re),
    .raddr_i (rd_idx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // ---------------------------------------------------------- edge tester
  pipt_edge_pipe #(
    .COORD_BITS (COORD_BITS)
  ) u_edge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step_q),
    .vx_i   (rdata[VW-1:COORD_BITS]),
    .vy_i   (rdata[COORD_BITS-1:0]),
    .pt_x_i (pt_x_q),
    .pt_y_i (pt_y_q),
    .ray_i  (ray_q),
    .res_o  (res)
  );

  assign out_valid_o      = out_valid_q;
  assign out_inside_res_o = out_inside_q;
  assign out_status_o     = out_status_q;
  assign out_overflowed_o = out_ovf_q;

  // ----------------------------------------------------------- assertions
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_VERTICES))
    else $error("vertex count beyond capacity");

  a_done_in_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.done |-> state_q == S_DRAIN)
    else $error("edge walk finished outside drain");

  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RESULT))
    else $error("result word raised without a finished query");

  a_error_not_inside : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_status_q == ST_RAY_ZERO || out_status_q == ST_EMPTY))
      |-> !out_inside_res_o)
    else $error("error result reports inside");

endmodule
